@@ rtl/core/lds_pkg.sv @@
// ----------------------------------------------------------------------------
// lds_pkg: shared types and codes of the linear Diophantine solver
// Result status codes and the handshake status of the shared divider unit.
// ----------------------------------------------------------------------------
package lds_pkg;

  // Result status codes.
  localparam logic [1:0] ST_SOLVED   = 2'd0;
  localparam logic [1:0] ST_NO_SOL   = 2'd1;
  localparam logic [1:0] ST_ZERO_AB  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Status of the iterative divider, as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/core/lds_div.sv @@
// ----------------------------------------------------------------------------
// lds_div: iterative restoring divider with quotient-product side channels
// Produces one quotient bit per cycle, and alongside it q*cx and q*cy by
// Horner accumulation, for the Bezout coefficient update.
// ----------------------------------------------------------------------------
module lds_div #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DATA_WIDTH-1:0]     dvd,
  input  logic [DATA_WIDTH-1:0]     dvs,
  input  logic [DATA_WIDTH+1:0]     cx,
  input  logic [DATA_WIDTH+1:0]     cy,
  output lds_pkg::div_stat_t        stat,
  output logic [DATA_WIDTH-1:0]     quo,
  output logic [DATA_WIDTH-1:0]     rmd,
  output logic [DATA_WIDTH+1:0]     prod_x,
  output logic [DATA_WIDTH+1:0]     prod_y
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [W:0]    p_r;
  logic [W-1:0]  dq_r, dvs_r, q_r;
  logic [W+1:0]  cx_r, cy_r, ax_r, ay_r;

  logic [W:0]    p_sh;
  logic          ge;

  assign p_sh = {p_r[W-1:0], dq_r[W-1]};
  assign ge   = (p_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
        p_r    <= '0;
        dq_r   <= dvd;
        dvs_r  <= dvs;
        cx_r   <= cx;
        cy_r   <= cy;
        q_r    <= '0;
        ax_r   <= '0;
        ay_r   <= '0;
      end else if (busy_r) begin
        p_r  <= ge ? (p_sh - {1'b0, dvs_r}) : p_sh;
        dq_r <= {dq_r[W-2:0], 1'b0};
        q_r  <= {q_r[W-2:0], ge};
        ax_r <= {ax_r[W:0], 1'b0} + (ge ? cx_r : '0);
        ay_r <= {ay_r[W:0], 1'b0} + (ge ? cy_r : '0);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = q_r;
  assign rmd       = p_r[W-1:0];
  assign prod_x    = ax_r;
  assign prod_y    = ay_r;

endmodule

@@ rtl/core/linear_diophantine_solver_core.sv @@
// ----------------------------------------------------------------------------
// linear_diophantine_solver_core: solves a*x + b*y = c over the integers
// Extended Euclid on |a| and |b|, then scaling and a run of solutions.
// ----------------------------------------------------------------------------
// Usage: an input beat (in_coef_a, in_coef_b, in_rhs_c, in_extra_count) is
// taken at a rising edge where start is high and busy is low. busy then stays
// high until the last result of that item has been issued; a=b=0 leaves it low.
// Each result beat is shown for exactly one cycle with out_valid high; the
// receiver cannot stall, so results flow out as soon as they are computed.
// out_last marks the final beat of an item.
// Flow: one shared restoring divider produces one quotient bit per cycle,
// and each Euclid step is one division; up to about 1.44*W steps may be
// needed. Three further divisions (c/g, a/g, b/g) follow, then two shift-add
// multiplications (base x and y). The solution run then issues one beat per
// cycle, up to MAX_EXTRA+1 beats. An item with a=b=0 is answered from idle.
// Reset (synchronous, rst_n low) returns the sequencer to idle and clears
// the output strobe; datapath registers are not cleared.
// ----------------------------------------------------------------------------
module linear_diophantine_solver_core #(
  parameter int DATA_WIDTH = 32,
  parameter int MAX_EXTRA  = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_WIDTH-1:0] in_coef_a,
  input  logic [DATA_WIDTH-1:0] in_coef_b,
  input  logic [DATA_WIDTH-1:0] in_rhs_c,
  input  logic [5:0]            in_extra_count,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_sol_x,
  output logic [DATA_WIDTH-1:0] out_sol_y,
  output logic [DATA_WIDTH-1:0] out_gcd_value,
  output logic [1:0]            out_status,
  output logic                  out_last
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W);

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EUC_CHK = 9'b000000010,
    S_EUC_DIV = 9'b000000100,
    S_CDIV    = 9'b000001000,
    S_ADIV    = 9'b000010000,
    S_BDIV    = 9'b000100000,
    S_MULX    = 9'b001000000,
    S_MULY    = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Item operands, stored as sign and magnitude.
  logic [W-1:0] ma_r, mb_r, mc_r;
  logic         na_r, nb_r, nc_r;
  logic [5:0]   n_r;

  // Euclid remainders and Bezout coefficients.
  logic [W-1:0] rem_prev_r, rem_cur_r;
  logic [W+1:0] bx_prev_r, bx_cur_r, by_prev_r, by_cur_r;

  // Scaling and stepping.
  logic [W-1:0]   cq_r;
  logic [W:0]     dxs_r, dys_r;
  logic [W-1:0]   x_r, y_r;
  logic [5:0]     emit_left_r;
  logic [2*W-1:0] acc_r;
  logic [CW-1:0]  mcnt_r;

  // Output registers.
  logic          ov_r, olast_r;
  logic [W-1:0]  ox_r, oy_r, og_r;
  logic [1:0]    ost_r;

  // Divider hookup.
  logic               div_start;
  logic [W-1:0]       div_dvd, div_dvs;
  lds_pkg::div_stat_t div_stat;
  logic [W-1:0]       div_quo, div_rmd;
  logic [W+1:0]       div_px, div_py;

  lds_div #(.DATA_WIDTH(W)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .dvd    (div_dvd),
    .dvs    (div_dvs),
    .cx     (bx_cur_r),
    .cy     (by_cur_r),
    .stat   (div_stat),
    .quo    (div_quo),
    .rmd    (div_rmd),
    .prod_x (div_px),
    .prod_y (div_py)
  );

  // Input sign and magnitude. The most negative value maps to 2^(W-1),
  // which still fits the unsigned magnitude.
  logic         in_na, in_nb, in_nc;
  logic [W-1:0] in_ma, in_mb, in_mc;
  logic         accept;
  logic [5:0]   n_sat;

  assign in_na  = in_coef_a[W-1];
  assign in_nb  = in_coef_b[W-1];
  assign in_nc  = in_rhs_c[W-1];
  assign in_ma  = in_na ? (~in_coef_a + 1'b1) : in_coef_a;
  assign in_mb  = in_nb ? (~in_coef_b + 1'b1) : in_coef_b;
  assign in_mc  = in_nc ? (~in_rhs_c + 1'b1) : in_rhs_c;
  assign accept = start && (state_r == S_IDLE);
  assign n_sat  = (in_extra_count > 6'(MAX_EXTRA)) ? 6'(MAX_EXTRA) : in_extra_count;

  // Multiplier operand: magnitude of the Bezout coefficient in use and the
  // sign of the scaled result.
  logic [W+1:0] coef_sel, coef_abs;
  logic         mul_neg;
  logic [2*W:0] acc_nxt, mul_lim;
  logic         mul_ovf;
  logic [W-1:0] mul_val;

  assign coef_sel = (state_r == S_MULY) ? by_prev_r : bx_prev_r;
  assign coef_abs = coef_sel[W+1] ? (~coef_sel + 1'b1) : coef_sel;
  assign mul_neg  = (state_r == S_MULY) ? (coef_sel[W+1] ^ nc_r ^ nb_r)
                                        : (coef_sel[W+1] ^ nc_r ^ na_r);
  assign acc_nxt  = {acc_r, 1'b0}
                  + (cq_r[mcnt_r] ? {{W{1'b0}}, coef_abs[W:0]} : '0);
  // The positive limit is 2^(W-1)-1, one more when the result is negative.
  assign mul_lim  = ((2*W+1)'(1) << (W - 1)) - (mul_neg ? '0 : (2*W+1)'(1));
  assign mul_ovf  = (acc_nxt > mul_lim);
  assign mul_val  = mul_neg ? (~acc_nxt[W-1:0] + 1'b1) : acc_nxt[W-1:0];

  // Next solution of the run: x + b/g and y - a/g, with a range check.
  logic [W+1:0] step_x, step_y;
  logic         step_ok;

  function automatic logic fits(input logic [W+1:0] v);
    fits = (v[W+1] == v[W]) && (v[W] == v[W-1]);
  endfunction

  assign step_x  = {{2{x_r[W-1]}}, x_r} + {dxs_r[W], dxs_r};
  assign step_y  = {{2{y_r[W-1]}}, y_r} + {dys_r[W], dys_r};
  assign step_ok = fits(step_x) && fits(step_y);

  // A result beat goes out next cycle whenever one of these holds.
  logic ov_set;

  always_comb begin
    ov_set = 1'b0;
    unique case (state_r)
      S_IDLE:  ov_set = accept && (in_ma == '0) && (in_mb == '0);
      S_CDIV:  ov_set = div_stat.done && (div_rmd != '0);
      S_MULX:  ov_set = (mcnt_r == '0) && mul_ovf;
      S_MULY:  ov_set = (mcnt_r == '0);
      S_EMIT:  ov_set = 1'b1;
      default: ov_set = 1'b0;
    endcase
  end

  // Divider launch: Euclid step, or one of the three closing divisions.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = rem_prev_r;
    div_dvs   = rem_cur_r;
    unique case (state_r)
      S_EUC_CHK: begin
        div_start = 1'b1;
        if (rem_cur_r == '0) begin
          div_dvd = mc_r;
          div_dvs = rem_prev_r;
        end
      end
      S_CDIV: begin
        div_start = div_stat.done && (div_rmd == '0);
        div_dvd   = ma_r;
        div_dvs   = rem_prev_r;
      end
      S_ADIV: begin
        div_start = div_stat.done;
        div_dvd   = mb_r;
        div_dvs   = rem_prev_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (start && !(in_ma == '0 && in_mb == '0)) state_nxt = S_EUC_CHK;
      S_EUC_CHK: state_nxt = (rem_cur_r == '0) ? S_CDIV : S_EUC_DIV;
      S_EUC_DIV: if (div_stat.done) state_nxt = S_EUC_CHK;
      S_CDIV:    if (div_stat.done) state_nxt = (div_rmd == '0) ? S_ADIV : S_IDLE;
      S_ADIV:    if (div_stat.done) state_nxt = S_BDIV;
      S_BDIV:    if (div_stat.done) state_nxt = S_MULX;
      S_MULX:    if (mcnt_r == '0) state_nxt = mul_ovf ? S_IDLE : S_MULY;
      S_MULY: begin
        if (mcnt_r == '0) begin
          state_nxt = (mul_ovf || n_r == '0) ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (!step_ok || emit_left_r == 6'd1) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_set;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            ma_r       <= in_ma;
            mb_r       <= in_mb;
            mc_r       <= in_mc;
            na_r       <= in_na;
            nb_r       <= in_nb;
            nc_r       <= in_nc;
            n_r        <= n_sat;
            rem_prev_r <= in_ma;
            rem_cur_r  <= in_mb;
            bx_prev_r  <= (W+2)'(1);
            bx_cur_r   <= '0;
            by_prev_r  <= '0;
            by_cur_r   <= (W+2)'(1);
            if (in_ma == '0 && in_mb == '0) begin
              ox_r    <= '0;
              oy_r    <= '0;
              og_r    <= '0;
              ost_r   <= lds_pkg::ST_ZERO_AB;
              olast_r <= 1'b1;
            end
          end
        end
        S_EUC_DIV: begin
          if (div_stat.done) begin
            rem_prev_r <= rem_cur_r;
            rem_cur_r  <= div_rmd;
            bx_prev_r  <= bx_cur_r;
            bx_cur_r   <= bx_prev_r - div_px;
            by_prev_r  <= by_cur_r;
            by_cur_r   <= by_prev_r - div_py;
          end
        end
        S_CDIV: begin
          if (div_stat.done) begin
            cq_r <= div_quo;
            if (div_rmd != '0) begin
              ox_r    <= '0;
              oy_r    <= '0;
              og_r    <= rem_prev_r;
              ost_r   <= lds_pkg::ST_NO_SOL;
              olast_r <= 1'b1;
            end
          end
        end
        S_ADIV: begin
          // Step for y is -a/g, with the sign of a folded in.
          if (div_stat.done) begin
            dys_r <= na_r ? {1'b0, div_quo} : (~{1'b0, div_quo} + 1'b1);
          end
        end
        S_BDIV: begin
          if (div_stat.done) begin
            dxs_r  <= nb_r ? (~{1'b0, div_quo} + 1'b1) : {1'b0, div_quo};
            acc_r  <= '0;
            mcnt_r <= CW'(W - 1);
          end
        end
        S_MULX: begin
          if (mcnt_r == '0) begin
            x_r    <= mul_val;
            acc_r  <= '0;
            mcnt_r <= CW'(W - 1);
            if (mul_ovf) begin
              ox_r    <= '0;
              oy_r    <= '0;
              og_r    <= rem_prev_r;
              ost_r   <= lds_pkg::ST_OVERFLOW;
              olast_r <= 1'b1;
            end
          end else begin
            acc_r  <= acc_nxt[2*W-1:0];
            mcnt_r <= mcnt_r - 1'b1;
          end
        end
        S_MULY: begin
          acc_r <= acc_nxt[2*W-1:0];
          if (mcnt_r == '0) begin
            y_r         <= mul_val;
            emit_left_r <= n_r;
            og_r        <= rem_prev_r;
            if (mul_ovf) begin
              ox_r    <= '0;
              oy_r    <= '0;
              ost_r   <= lds_pkg::ST_OVERFLOW;
              olast_r <= 1'b1;
            end else begin
              ox_r    <= x_r;
              oy_r    <= mul_val;
              ost_r   <= lds_pkg::ST_SOLVED;
              olast_r <= (n_r == '0);
            end
          end else begin
            mcnt_r <= mcnt_r - 1'b1;
          end
        end
        S_EMIT: begin
          og_r        <= rem_prev_r;
          emit_left_r <= emit_left_r - 1'b1;
          x_r         <= step_x[W-1:0];
          y_r         <= step_y[W-1:0];
          if (step_ok) begin
            ox_r    <= step_x[W-1:0];
            oy_r    <= step_y[W-1:0];
            ost_r   <= lds_pkg::ST_SOLVED;
            olast_r <= (emit_left_r == 6'd1);
          end else begin
            ox_r    <= '0;
            oy_r    <= '0;
            ost_r   <= lds_pkg::ST_OVERFLOW;
            olast_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = ov_r;
  assign out_sol_x     = ox_r;
  assign out_sol_y     = oy_r;
  assign out_gcd_value = og_r;
  assign out_status    = ost_r;
  assign out_last      = olast_r;

`ifndef ASSERT_OFF
  // A beat that is not the last of its item leaves the block still busy.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result while idle");

  // An accepted item either starts the sequencer or answers at once.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || (out_valid && out_last))
    else $error("accepted item neither started nor answered");

  // Any status other than solved ends the item, with x and y both zero.
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != lds_pkg::ST_SOLVED |->
      out_last && out_sol_x == '0 && out_sol_y == '0)
    else $error("failure result is not final or carries a solution");

  // The shared divider is only launched while it is idle.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider launched while busy");
`endif

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for linear_diophantine_solver_core
// Drives input beats in random bursts, predicts the result beats of each
// item with its own extended Euclid model, and checks every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int W = 32;
  localparam int MAXX = 63;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint NEG_MIN = -64'sd2147483648;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] c;
    logic [5:0]   n;
  } eq_item_t;

  typedef struct packed {
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] g;
    logic [1:0]   st;
    logic         last;
  } sol_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [W-1:0] in_coef_a = '0;
  logic [W-1:0] in_coef_b = '0;
  logic [W-1:0] in_rhs_c = '0;
  logic [5:0] in_extra_count = '0;
  logic out_valid;
  logic [W-1:0] out_sol_x;
  logic [W-1:0] out_sol_y;
  logic [W-1:0] out_gcd_value;
  logic [1:0] out_status;
  logic out_last;

  eq_item_t pending_eqs[$];
  sol_beat_t expected_sols[$];
  int errors = 0;
  longint cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit stim_done = 1'b0;

  linear_diophantine_solver_core #(.DATA_WIDTH(W), .MAX_EXTRA(MAXX)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_rhs_c(in_rhs_c),
    .in_extra_count(in_extra_count), .out_valid(out_valid),
    .out_sol_x(out_sol_x), .out_sol_y(out_sol_y),
    .out_gcd_value(out_gcd_value), .out_status(out_status),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Appends one result beat to the store of expected solutions.
  function automatic void push_sol(longint x, longint y, longint g,
                                   logic [1:0] st, bit last);
    sol_beat_t s;
    s.x = x[W-1:0];
    s.y = y[W-1:0];
    s.g = g[W-1:0];
    s.st = st;
    s.last = last;
    expected_sols.insert(expected_sols.size(), s);
  endfunction

  // Extended Euclid on the magnitudes, then scaling and the solution run.
  // Magnitudes fit in 33 bits, so 64-bit signed math is exact throughout.
  function automatic void solve_equation(eq_item_t it);
    longint ma, mb, mc, sa, sb, sc;
    longint r0, r1, x0, x1, y0, y1, q, t, g, cq, bx, by, dx, dy;
    int n;
    sa = longint'(signed'(it.a));
    sb = longint'(signed'(it.b));
    sc = longint'(signed'(it.c));
    ma = sa < 0 ? -sa : sa;
    mb = sb < 0 ? -sb : sb;
    mc = sc < 0 ? -sc : sc;
    n = it.n;
    if (ma == 0 && mb == 0) begin
      push_sol(0, 0, 0, lds_pkg::ST_ZERO_AB, 1'b1);
      return;
    end
    r0 = ma; r1 = mb; x0 = 1; x1 = 0; y0 = 0; y1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      t = r0 - q * r1; r0 = r1; r1 = t;
      t = x0 - q * x1; x0 = x1; x1 = t;
      t = y0 - q * y1; y0 = y1; y1 = t;
    end
    g = r0;
    if (mc % g != 0) begin
      push_sol(0, 0, g, lds_pkg::ST_NO_SOL, 1'b1);
      return;
    end
    cq = mc / g;
    // Bezout coefficients are bounded by the magnitudes, so the product of
    // one with cq can exceed 2^31 in magnitude; guard by division.
    if ((x0 != 0 && cq > (POS_MAX + 1) / (x0 < 0 ? -x0 : x0)) ||
        (y0 != 0 && cq > (POS_MAX + 1) / (y0 < 0 ? -y0 : y0))) begin
      push_sol(0, 0, g, lds_pkg::ST_OVERFLOW, 1'b1);
      return;
    end
    bx = x0 * cq;
    by = y0 * cq;
    if (sc < 0) begin bx = -bx; by = -by; end
    if (sa < 0) bx = -bx;
    if (sb < 0) by = -by;
    if (bx > POS_MAX || bx < NEG_MIN || by > POS_MAX || by < NEG_MIN) begin
      push_sol(0, 0, g, lds_pkg::ST_OVERFLOW, 1'b1);
      return;
    end
    dx = (sb < 0) ? -(mb / g) : mb / g;
    dy = (sa < 0) ? -(ma / g) : ma / g;
    push_sol(bx, by, g, lds_pkg::ST_SOLVED, n == 0);
    for (int k = 1; k <= n; k++) begin
      bx += dx;
      by -= dy;
      if (bx > POS_MAX || bx < NEG_MIN || by > POS_MAX || by < NEG_MIN) begin
        push_sol(0, 0, g, lds_pkg::ST_OVERFLOW, 1'b1);
        return;
      end
      push_sol(bx, by, g, lds_pkg::ST_SOLVED, k == n);
    end
  endfunction

  function automatic logic [W-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return W'($urandom_range(0, 40)) - W'(20);
      1: return W'($urandom_range(0, 2000)) - W'(1000);
      2: return $urandom;
      3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
      default: return W'($urandom_range(0, 200000)) - W'(100000);
    endcase
  endfunction

  function automatic void add_eq(logic [W-1:0] a, logic [W-1:0] b,
                                 logic [W-1:0] c, logic [5:0] n);
    eq_item_t it;
    it.a = a; it.b = b; it.c = c; it.n = n;
    pending_eqs.insert(pending_eqs.size(), it);
  endfunction

  initial begin
    logic [W-1:0] a, b, g;
    // Directed part: zero coefficients, no solution, extremes, overflow.
    add_eq(0, 0, 5, 6'd3);
    add_eq(0, 0, 0, 6'd0);
    add_eq(4, 6, 7, 6'd2);
    add_eq(3, 5, 0, 6'd4);
    add_eq(3, 5, 1, 6'd63);
    add_eq(-3, 5, 7, 6'd5);
    add_eq(3, -5, -7, 6'd5);
    add_eq(-3, -5, -7, 6'd5);
    add_eq(0, 7, 14, 6'd2);
    add_eq(9, 0, -27, 6'd2);
    add_eq(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 6'd1);
    add_eq(32'h8000_0000, 1, 32'h7fff_ffff, 6'd3);
    add_eq(32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0000, 6'd2);
    add_eq(1, 32'h7fff_ffff, 32'h7fff_ffff, 6'd63);
    add_eq(32'h7fff_fffe, 3, 32'h7fff_ffff, 6'd1);
    add_eq(1, 32'h4000_0000, 32'h7fff_fff0, 6'd4);
    add_eq(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 6'd63);
    add_eq(1_134_903_170, 1_836_311_903, 1, 6'd2);
    add_eq(-1_836_311_903, 1_134_903_170, -5, 6'd2);
    add_eq(6, 10, 32'h7fff_fffe, 6'd0);
    for (int i = 0; i < 270; i++) begin
      a = rand_coef();
      b = rand_coef();
      if ($urandom_range(0, 3) != 0) begin
        // Mostly: a and b scaled by a small common factor, c small.
        g = W'($urandom_range(1, 9));
        a = a * g; b = b * g;
        add_eq(a, b, W'($urandom_range(0, 400)) - W'(200), 6'($urandom));
      end else begin
        add_eq(a, b, $urandom_range(0, 1) ? rand_coef() : $urandom, 6'($urandom));
      end
    end
    stim_done = 1'b1;
  end

  // Driver: raises start for one beat at a time, in bursts with gaps.
  always @(posedge clk) begin
    eq_item_t it;
    cycles <= cycles + 1;
    if (cycles == 4) rst_n <= 1'b1;
    if (rst_n) begin
      if (start && !busy) begin
        // The beat in flight was just taken.
        start <= 1'b0;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
          burst_left <= $urandom_range(0, 8);
        end
      end else if (!start && gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (!start && pending_eqs.size() > 0) begin
        it = pending_eqs.pop_front();
        solve_equation(it);
        in_coef_a <= it.a;
        in_coef_b <= it.b;
        in_rhs_c <= it.c;
        in_extra_count <= it.n;
        start <= 1'b1;
      end
    end
  end

  // Monitor: every strobed beat is compared with the oldest expectation.
  always @(posedge clk) begin
    sol_beat_t want;
    if (rst_n && out_valid) begin
      if (expected_sols.size() == 0) begin
        $display("%0t: unexpected result beat x=%0d y=%0d g=%0d st=%0d last=%0b",
                 $time, $signed(out_sol_x), $signed(out_sol_y), out_gcd_value,
                 out_status, out_last);
        errors <= errors + 1;
      end else begin
        want = expected_sols.pop_front();
        if (want.x !== out_sol_x || want.y !== out_sol_y ||
            want.g !== out_gcd_value || want.st !== out_status ||
            want.last !== out_last) begin
          $display("%0t: mismatch expected x=%0d y=%0d g=%0d st=%0d last=%0b",
                   $time, $signed(want.x), $signed(want.y), want.g, want.st,
                   want.last);
          $display("%0t:          actual   x=%0d y=%0d g=%0d st=%0d last=%0b",
                   $time, $signed(out_sol_x), $signed(out_sol_y), out_gcd_value,
                   out_status, out_last);
          errors <= errors + 1;
        end
      end
    end
  end

  // End of run: all items taken, nothing outstanding, then a short drain.
  initial begin
    wait (stim_done && pending_eqs.size() == 0 && !start &&
          expected_sols.size() == 0 && rst_n);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_sols.size() == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
